FILE: rtl/tdf_pkg.sv
`default_nettype none
package tdf_pkg;
  localparam int MAX_FACTORS_DEF = 30;
  localparam int VALUE_WIDTH_DEF = 31;
  localparam int SMALL_W = 5;
  localparam int TRIAL_START = 2;
endpackage
`default_nettype wire

FILE: rtl/tdf_if.sv
`default_nettype none
interface tdf_in_if #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface tdf_out_if #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [VALUE_WIDTH-1:0]     factor;
  logic [VALUE_WIDTH-1:0]     dividend;
  logic [tdf_pkg::SMALL_W-1:0] step_index;
  logic [tdf_pkg::SMALL_W-1:0] factor_count;
  logic                       last;

  modport source (output valid, output factor, output dividend, output step_index,
                  output factor_count, output last, input ready);
  modport sink (input valid, input factor, input dividend, input step_index,
                input factor_count, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/tdf_divider.sv
`default_nettype none
module tdf_divider #(
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient,
  output logic [VALUE_WIDTH-1:0]      remainder
);
  localparam int NW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [NW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [VALUE_WIDTH:0]   partial;
  logic [VALUE_WIDTH:0]   diff;

  assign partial = {rem_r, q_r[VALUE_WIDTH-1]};
  assign diff = partial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = NW'(VALUE_WIDTH);
      q_nxt = dividend;
      rem_nxt = '0;
      d_nxt = divisor;
    end else if (busy_r) begin
      if (partial >= {1'b0, d_r}) begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
        q_nxt = {q_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = partial[VALUE_WIDTH-1:0];
        q_nxt = {q_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

FILE: rtl/tdf_store.sv
`default_nettype none
module tdf_store #(
  parameter int DEPTH = tdf_pkg::MAX_FACTORS_DEF,
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [VALUE_WIDTH-1:0] wr_factor,
  input  wire logic [VALUE_WIDTH-1:0] wr_dividend,
  input  wire logic [AW-1:0]          rd_factor_addr,
  input  wire logic [AW-1:0]          rd_dividend_addr,
  output logic [VALUE_WIDTH-1:0]      rd_factor,
  output logic [VALUE_WIDTH-1:0]      rd_dividend
);
  logic [VALUE_WIDTH-1:0] factor_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] dividend_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      factor_mem[wr_addr] <= wr_factor;
      dividend_mem[wr_addr] <= wr_dividend;
    end
    rd_factor <= factor_mem[rd_factor_addr];
    rd_dividend <= dividend_mem[rd_dividend_addr];
  end
endmodule
`default_nettype wire

FILE: rtl/trial_division_factorizer_core.sv
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    value
// out_ch   out  valid/ready    factor, dividend, step_index, factor_count, last
// cfg      in   cfg_we         cfg_wdata (descending order bit)
//
// Each trial divisor costs one pass through the shared bit-serial divider.
// An item takes one divider pass per trial divisor and per factor found,
// with up to about sqrt(value) trials, plus a store read before each result.
// A value below two causes no result and leaves the input ready.
// Reset is synchronous and active low; the stores hold no reset value.
// The input is not ready from acceptance until the last result transfer.
`default_nettype none
module trial_division_factorizer_core #(
  parameter int MAX_FACTORS = tdf_pkg::MAX_FACTORS_DEF,
  parameter int VALUE_WIDTH = tdf_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tdf_in_if.sink    in_ch,
  tdf_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  localparam int CW = $clog2(MAX_FACTORS + 1);
  localparam int AW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_TRIAL, S_WAIT, S_READ, S_OUT} state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] div_r, div_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic                   desc_r;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quot;
  logic [VALUE_WIDTH-1:0] remd;
  logic                   wr_en;
  logic [VALUE_WIDTH-1:0] wr_factor;
  logic [CW-1:0]          src;
  logic                   is_last;

  tdf_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rem_r), .divisor(div_r),
    .done(div_done), .quotient(quot), .remainder(remd)
  );

  assign src = desc_r ? CW'(count_r - CW'(1) - k_r) : k_r;

  tdf_store #(.DEPTH(MAX_FACTORS), .VALUE_WIDTH(VALUE_WIDTH)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(count_r[AW-1:0]), .wr_factor(wr_factor),
    .wr_dividend(rem_r), .rd_factor_addr(src[AW-1:0]), .rd_dividend_addr(k_r[AW-1:0]),
    .rd_factor(out_ch.factor), .rd_dividend(out_ch.dividend)
  );

  assign is_last = (k_r + CW'(1)) == count_r;

  always_comb begin
    state_nxt = state_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    count_nxt = count_r;
    k_nxt = k_r;
    div_start = 1'b0;
    wr_en = 1'b0;
    wr_factor = div_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          rem_nxt = in_ch.value;
          div_nxt = VALUE_WIDTH'(tdf_pkg::TRIAL_START);
          count_nxt = '0;
          k_nxt = '0;
          if (in_ch.value >= VALUE_WIDTH'(tdf_pkg::TRIAL_START)) begin
            state_nxt = S_TRIAL;
          end
        end
      end
      S_TRIAL: begin
        if (rem_r > VALUE_WIDTH'(1) && count_r != CW'(MAX_FACTORS)) begin
          div_start = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          if (div_r > quot) begin
            wr_en = 1'b1;
            wr_factor = rem_r;
            rem_nxt = VALUE_WIDTH'(1);
            count_nxt = count_r + CW'(1);
          end else if (remd == '0) begin
            wr_en = 1'b1;
            rem_nxt = quot;
            count_nxt = count_r + CW'(1);
          end else begin
            div_nxt = div_r + VALUE_WIDTH'(1);
          end
          state_nxt = S_TRIAL;
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + CW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      k_r <= '0;
      desc_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r <= k_nxt;
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign in_ch.ready = state_r == S_IDLE;
  assign out_ch.valid = state_r == S_OUT;
  assign out_ch.step_index = tdf_pkg::SMALL_W'(k_r);
  assign out_ch.factor_count = tdf_pkg::SMALL_W'(count_r);
  assign out_ch.last = is_last;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("result offered while input is ready");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_WAIT)
    else $error("divider finished outside the wait state");

  a_small_value: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.value < VALUE_WIDTH'(tdf_pkg::TRIAL_START))
    |=> in_ch.ready)
    else $error("value below two did not return to idle");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("input not ready after the last transfer");

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> count_r != CW'(MAX_FACTORS))
    else $error("store written beyond its depth");
endmodule
`default_nettype wire

FILE: dv/tb_trial_division_factorizer_core.sv
module tb_trial_division_factorizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = tdf_pkg::VALUE_WIDTH_DEF;
  localparam int SW = tdf_pkg::SMALL_W;
  localparam int MAX_FACT = tdf_pkg::MAX_FACTORS_DEF;
  localparam longint unsigned VALUE_MAX = (64'd1 << VW) - 1;
  localparam int STALL_LIMIT = 250000;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_CORNERS = 19;
  localparam longint unsigned CORNER_VALUES [NUM_CORNERS] = '{
    2, 3, 4, 0, 1, 9, 25, 35, 30, 961, 1024, 510510, 1073741824, 2147483646,
    1610612736, 1073741825, 1042441, 1000003, 2000006
  };

  typedef struct packed {
    logic [VW-1:0] factor;
    logic [VW-1:0] dividend;
    logic [SW-1:0] step_index;
    logic [SW-1:0] factor_count;
    logic          last;
  } factor_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  tdf_in_if #(.VALUE_WIDTH(VW)) in_ch ();
  tdf_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  trial_division_factorizer_core #(
    .MAX_FACTORS(MAX_FACT),
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [VW-1:0]  pending_values[$];
  factor_result_t factor_results_due[$];
  factor_result_t due;
  bit             order_desc;
  bit             no_idle;
  bit             hold_go;
  logic           rx_hold;
  int             in_gap;
  int             out_gap;
  int             fail_count;
  int             stall_cycles;

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic void predict_factors(input logic [VW-1:0] n);
    longint unsigned rest;
    longint unsigned div;
    longint unsigned primes[$];
    longint unsigned dividends[$];
    int num;
    factor_result_t r;
    rest = 64'(n);
    div = 64'(tdf_pkg::TRIAL_START);
    while (rest > 1 && primes.size() < MAX_FACT) begin
      if (div > rest / div) begin
        primes.push_back(rest);
        dividends.push_back(rest);
        rest = 1;
      end else if (rest % div == 0) begin
        primes.push_back(div);
        dividends.push_back(rest);
        rest = rest / div;
      end else begin
        div++;
      end
    end
    num = primes.size();
    for (int k = 0; k < num; k++) begin
      r.factor = VW'(order_desc ? primes[num - 1 - k] : primes[k]);
      r.dividend = VW'(dividends[k]);
      r.step_index = SW'(k);
      r.factor_count = SW'(num);
      r.last = (k == num - 1);
      factor_results_due.push_back(r);
    end
  endfunction

  function automatic logic [VW-1:0] smooth_value();
    longint unsigned prod;
    longint unsigned f;
    longint unsigned top;
    longint unsigned cap;
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 15) return VW'($urandom_range(0, 1000));
    top = (sel < 60) ? 15 : (sel < 90) ? 127 : 1023;
    n = $urandom_range(1, 30);
    prod = 1;
    for (int i = 0; i < n; i++) begin
      f = 64'($urandom_range(2, 32'(top)));
      if (prod * f > VALUE_MAX) break;
      prod = prod * f;
    end
    cap = VALUE_MAX / prod;
    if ($urandom_range(0, 4) == 0 && cap >= 2)
      prod = prod * 64'($urandom_range(1, 32'((cap > 65536) ? 65536 : cap)));
    return VW'(prod);
  endfunction

  task automatic write_order(input bit desc);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_desc = desc;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_values.size() != 0 || in_ch.valid || factor_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int num);
    @(negedge clk);
    repeat (num) pending_values.push_back(smooth_value());
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_factors(in_ch.value);
        pending_values.delete(0);
        in_gap = pick_gap();
      end
      if (in_gap != 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_values.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.value <= pending_values[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (factor_results_due.size() == 0) begin
          $error("unexpected result transfer: factor %0d", out_ch.factor);
          fail_count++;
        end else begin
          due = factor_results_due.pop_front();
          if (out_ch.factor !== due.factor) begin
            $error("factor: expected %0d, got %0d", due.factor, out_ch.factor);
            fail_count++;
          end
          if (out_ch.dividend !== due.dividend) begin
            $error("dividend: expected %0d, got %0d", due.dividend, out_ch.dividend);
            fail_count++;
          end
          if (out_ch.step_index !== due.step_index) begin
            $error("step_index: expected %0d, got %0d", due.step_index, out_ch.step_index);
            fail_count++;
          end
          if (out_ch.factor_count !== due.factor_count) begin
            $error("factor_count: expected %0d, got %0d", due.factor_count,
                   out_ch.factor_count);
            fail_count++;
          end
          if (out_ch.last !== due.last) begin
            $error("last: expected %0d, got %0d", due.last, out_ch.last);
            fail_count++;
          end
        end
        out_gap = pick_gap();
      end else if (out_gap != 0) begin
        out_gap--;
      end
      out_ch.ready <= !rx_hold && (out_gap == 0);
    end
  end

  // The receiver goes quiet once the first result shows up, so the block backs up.
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    do @(posedge clk);
    while (!out_ch.valid);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    order_desc = 1'b0;
    no_idle = 1'b0;
    hold_go = 1'b0;
    fail_count = 0;
    stall_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_order(1'b0);
    @(negedge clk);
    hold_go = 1'b1;
    foreach (CORNER_VALUES[i]) pending_values.push_back(VW'(CORNER_VALUES[i]));
    wait_idle();

    write_order(1'b1);
    no_idle = 1'b1;
    queue_random(35);
    wait_idle();

    write_order(1'b0);
    no_idle = 1'b0;
    queue_random(35);
    wait_idle();

    write_order(1'b1);
    queue_random(30);
    wait_idle();

    if (fail_count == 0 && factor_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
